/* sv/rtm_pkg.sv */
// ----------------------------------------------------------------------------
// Retransmit timer package
// Shared widths, command codes, register indexes and transaction types.
// ----------------------------------------------------------------------------
package rtm_pkg;

	localparam int unsigned HANDLE_W = 16;
	localparam int unsigned COUNT_W = 16;
	localparam int unsigned TIME_W = 64;
	localparam int unsigned CHAN_W = 3;
	localparam int unsigned CMD_W = 2;
	localparam int unsigned DELAY_W = 32;
	localparam int unsigned NUM_REGS = 7;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned NUM_DELAY_REGS = 5;
	localparam int unsigned TB_CH = 1;
	localparam int unsigned DEFAULT_NUM_CHANNELS = 5;

	localparam logic [DELAY_W-1:0] DELAY_RESET = 32'd1000000000;

	localparam logic [CFG_IDX_W-1:0] REG_TB_FIRST = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CHECK_INTERVAL = 3'd6;

	localparam logic [CMD_W-1:0] CMD_START = 2'd0;
	localparam logic [CMD_W-1:0] CMD_STOP = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CHECK = 2'd2;
	localparam logic [CMD_W-1:0] CMD_BEGIN_TB = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [CHAN_W-1:0] channel;
		logic [TIME_W-1:0] now_time;
		logic [HANDLE_W-1:0] msg_handle;
	} in_item_t;

	typedef struct packed {
		logic [CHAN_W-1:0] out_channel;
		logic [HANDLE_W-1:0] out_handle;
		logic [COUNT_W-1:0] attempt_count;
		logic retransmit;
		logic accepted;
		logic replaced;
		logic [TIME_W-1:0] next_wake;
		logic last;
	} out_item_t;

	typedef struct packed {
		logic [TIME_W-1:0] deadline;
		logic [HANDLE_W-1:0] handle;
		logic [COUNT_W-1:0] count;
	} chan_entry_t;

	typedef struct packed {
		logic [DELAY_W-1:0] sel_delay;
		logic [DELAY_W-1:0] tb_first_delay;
		logic [DELAY_W-1:0] check_interval;
	} cfg_view_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_EXEC,
		SEQ_FINAL
	} seq_state_t;

endpackage

/* sv/rtm_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Retransmit timer configuration registers
// Holds the channel periods, the first TB delay and the check interval.
// ----------------------------------------------------------------------------
module rtm_cfg_regs import rtm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DELAY_W-1:0]   cfg_data,
	input  logic [CHAN_W-1:0]    delay_sel,
	output cfg_view_t            view
);

	logic [DELAY_W-1:0] regs_q [NUM_REGS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				regs_q[i] <= DELAY_RESET;
			end
		end else if (cfg_write_en && (32'(cfg_index) < NUM_REGS)) begin
			regs_q[cfg_index] <= cfg_data;
		end
	end

	always_comb begin
		view.sel_delay = (32'(delay_sel) < NUM_DELAY_REGS) ? regs_q[delay_sel] : '0;
		view.tb_first_delay = regs_q[REG_TB_FIRST];
		view.check_interval = regs_q[REG_CHECK_INTERVAL];
	end

endmodule

/* sv/rtm_chan_mem.sv */
// ----------------------------------------------------------------------------
// Retransmit timer channel memory
// One entry per channel with a registered read port and a write port.
// Entries that were never written read as zero.
// ----------------------------------------------------------------------------
module rtm_chan_mem import rtm_pkg::*; #(
	parameter int unsigned NUM_CHANNELS = DEFAULT_NUM_CHANNELS,
	localparam int unsigned IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_addr,
	output chan_entry_t      rd_data,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  chan_entry_t      wr_data
);

	chan_entry_t ram_q [NUM_CHANNELS];
	chan_entry_t rd_word_q;
	logic [NUM_CHANNELS-1:0] valid_q;
	logic rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ram_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_word_q <= ram_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_word_q : '0;

endmodule

/* sv/rtm_seq.sv */
// ----------------------------------------------------------------------------
// Retransmit timer sequencer
// Runs one command at a time: reads the channel entry, updates it, writes
// it back and loads each result into the output register.
// ----------------------------------------------------------------------------
module rtm_seq import rtm_pkg::*; #(
	parameter int unsigned NUM_CHANNELS = DEFAULT_NUM_CHANNELS,
	localparam int unsigned IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_item_t          in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output out_item_t         out_data,
	input  cfg_view_t         cfg,
	output logic [CHAN_W-1:0] delay_sel,
	output logic              mem_rd_en,
	output logic [IDX_W-1:0]  mem_rd_addr,
	input  chan_entry_t       mem_rd_data,
	output logic              mem_wr_en,
	output logic [IDX_W-1:0]  mem_wr_addr,
	output chan_entry_t       mem_wr_data
);

	localparam int unsigned SCAN_N = (NUM_CHANNELS < NUM_DELAY_REGS) ? NUM_CHANNELS
		: NUM_DELAY_REGS;
	localparam bit TB_EXISTS = (NUM_CHANNELS >= 2);
	localparam logic [IDX_W-1:0] TB_ADDR = IDX_W'(TB_CH);
	localparam logic [IDX_W-1:0] LAST_SCAN = IDX_W'(SCAN_N - 1);

	seq_state_t state_q, state_d;
	logic [CMD_W-1:0] cmd_q;
	logic [CHAN_W-1:0] ch_q;
	logic [TIME_W-1:0] now_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [IDX_W-1:0] scan_q;
	logic [TIME_W-1:0] earliest_q;
	logic [NUM_CHANNELS-1:0] active_q;
	logic out_valid_q;
	out_item_t out_q;

	logic accept;
	logic slot_free;
	logic ch_in_range;
	logic [IDX_W-1:0] ch_addr;
	logic [IDX_W-1:0] accept_addr;
	logic scan_active;
	logic tb_active;
	logic overdue;
	logic last_scan;
	logic [DELAY_W-1:0] add_b;
	logic [TIME_W-1:0] add_a;
	logic [TIME_W-1:0] sum;
	logic [COUNT_W-1:0] count_inc;
	logic step;
	logic load;
	out_item_t res;
	logic act_wr;
	logic act_val;
	logic earliest_upd;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == SEQ_IDLE);
	assign accept = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	assign ch_in_range = (32'(ch_q) < NUM_CHANNELS);
	assign ch_addr = IDX_W'(ch_q);
	assign scan_active = active_q[scan_q];
	assign tb_active = TB_EXISTS && active_q[TB_ADDR];
	assign overdue = (now_q > mem_rd_data.deadline);
	assign last_scan = (scan_q == LAST_SCAN);

	assign delay_sel = (cmd_q == CMD_CHECK) ? CHAN_W'(scan_q) : ch_q;
	assign add_a = (cmd_q == CMD_CHECK) ? mem_rd_data.deadline : now_q;
	assign add_b = (cmd_q == CMD_BEGIN_TB) ? cfg.tb_first_delay : cfg.sel_delay;
	assign sum = add_a + TIME_W'(add_b);
	assign count_inc = (&mem_rd_data.count) ? mem_rd_data.count
		: mem_rd_data.count + COUNT_W'(1);

	always_comb begin
		case (in_data.cmd)
			CMD_START, CMD_STOP: accept_addr = IDX_W'(in_data.channel);
			CMD_BEGIN_TB:        accept_addr = TB_ADDR;
			default:             accept_addr = '0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			SEQ_IDLE: begin
				if (accept) begin
					state_d = SEQ_EXEC;
				end
			end
			SEQ_EXEC: begin
				if (step) begin
					if (cmd_q != CMD_CHECK) begin
						state_d = SEQ_IDLE;
					end else if (last_scan) begin
						state_d = SEQ_FINAL;
					end
				end
			end
			SEQ_FINAL: begin
				if (slot_free) begin
					state_d = SEQ_IDLE;
				end
			end
			default: state_d = SEQ_IDLE;
		endcase
	end

	always_comb begin
		mem_rd_en = 1'b0;
		mem_rd_addr = accept_addr;
		mem_wr_en = 1'b0;
		mem_wr_addr = ch_addr;
		mem_wr_data = mem_rd_data;
		step = 1'b0;
		load = 1'b0;
		res = '0;
		res.last = 1'b1;
		act_wr = 1'b0;
		act_val = 1'b0;
		earliest_upd = 1'b0;
		case (state_q)
			SEQ_IDLE: begin
				mem_rd_en = accept;
			end
			SEQ_EXEC: begin
				case (cmd_q)
					CMD_START: begin
						step = slot_free;
						load = slot_free;
						res.out_channel = ch_q;
						if (ch_in_range) begin
							res.out_handle = handle_q;
							res.accepted = 1'b1;
							res.next_wake = sum;
							mem_wr_en = slot_free;
							mem_wr_data.deadline = sum;
							mem_wr_data.handle = handle_q;
							mem_wr_data.count = '0;
							act_wr = slot_free;
							act_val = 1'b1;
						end
					end
					CMD_STOP: begin
						step = slot_free;
						load = slot_free;
						res.out_channel = ch_q;
						if (ch_in_range) begin
							res.attempt_count = mem_rd_data.count;
							res.accepted = 1'b1;
							mem_wr_en = slot_free;
							mem_wr_data.handle = '0;
							act_wr = slot_free;
							act_val = 1'b0;
						end
					end
					CMD_BEGIN_TB: begin
						step = slot_free;
						load = slot_free;
						mem_wr_addr = TB_ADDR;
						res.out_channel = CHAN_W'(TB_CH);
						if (TB_EXISTS) begin
							if (tb_active) begin
								if (mem_rd_data.count != '0) begin
									res.attempt_count = mem_rd_data.count;
								end else begin
									res.out_handle = mem_rd_data.handle;
									res.accepted = 1'b1;
									res.replaced = 1'b1;
									res.next_wake = mem_rd_data.deadline;
									mem_wr_en = slot_free;
									mem_wr_data.handle = handle_q;
								end
							end else begin
								res.accepted = 1'b1;
								res.next_wake = sum;
								mem_wr_en = slot_free;
								mem_wr_data.deadline = sum;
								mem_wr_data.handle = handle_q;
								mem_wr_data.count = '0;
								act_wr = slot_free;
								act_val = 1'b1;
							end
						end
					end
					CMD_CHECK: begin
						mem_wr_addr = scan_q;
						if (scan_active && overdue) begin
							step = slot_free;
							load = slot_free;
							res.out_channel = CHAN_W'(scan_q);
							res.out_handle = mem_rd_data.handle;
							res.attempt_count = count_inc;
							res.retransmit = 1'b1;
							res.accepted = 1'b1;
							res.last = 1'b0;
							mem_wr_en = slot_free;
							mem_wr_data.deadline = sum;
							mem_wr_data.count = count_inc;
						end else begin
							step = 1'b1;
							earliest_upd = scan_active
								&& (mem_rd_data.deadline < earliest_q);
						end
						if (step && !last_scan) begin
							mem_rd_en = 1'b1;
							mem_rd_addr = scan_q + IDX_W'(1);
						end
					end
					default: step = 1'b1;
				endcase
			end
			SEQ_FINAL: begin
				load = slot_free;
				res.accepted = 1'b1;
				res.next_wake = earliest_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
			out_valid_q <= 1'b0;
			active_q <= '0;
			scan_q <= '0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (act_wr) begin
				active_q[mem_wr_addr] <= act_val;
			end
			if (accept) begin
				scan_q <= '0;
			end else if (state_q == SEQ_EXEC && cmd_q == CMD_CHECK && step && !last_scan) begin
				scan_q <= scan_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= in_data.cmd;
			ch_q <= in_data.channel;
			now_q <= in_data.now_time;
			handle_q <= in_data.msg_handle;
			earliest_q <= in_data.now_time + TIME_W'(cfg.check_interval);
		end else if (earliest_upd) begin
			earliest_q <= mem_rd_data.deadline;
		end
		if (load) begin
			out_q <= res;
		end
	end

endmodule

/* sv/multi_channel_retransmit_timer_top.sv */
// ----------------------------------------------------------------------------
// Multi-channel retransmit timer
// Keeps per-channel deadlines, handles and attempt counts and reports
// overdue channels on a check command.
// ----------------------------------------------------------------------------
// Commands are handled one at a time. Start, stop and begin TB first read
// the channel entry from the channel memory, then update it and load the
// result. A check walks the channels through that memory one entry per
// cycle unless a resend result stalls it, writing back an overdue entry
// while it reads the next, and each resend result waits for the output
// register to be free. A new command is taken once the previous one has
// loaded its final result, even while that result still waits to be
// taken. All times wrap modulo 2^64.
module multi_channel_retransmit_timer_top import rtm_pkg::*; #(
	parameter int unsigned NUM_CHANNELS = DEFAULT_NUM_CHANNELS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_data,
	input  logic                 cfg_write_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DELAY_W-1:0]   cfg_data
);

	localparam int unsigned IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	cfg_view_t cfg_view;
	logic [CHAN_W-1:0] delay_sel;
	logic mem_rd_en;
	logic [IDX_W-1:0] mem_rd_addr;
	chan_entry_t mem_rd_data;
	logic mem_wr_en;
	logic [IDX_W-1:0] mem_wr_addr;
	chan_entry_t mem_wr_data;

	rtm_cfg_regs u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.delay_sel    (delay_sel),
		.view         (cfg_view)
	);

	rtm_chan_mem #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data)
	);

	rtm_seq #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.cfg         (cfg_view),
		.delay_sel   (delay_sel),
		.mem_rd_en   (mem_rd_en),
		.mem_rd_addr (mem_rd_addr),
		.mem_rd_data (mem_rd_data),
		.mem_wr_en   (mem_wr_en),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data)
	);

`ifndef ASSERT_OFF
	// A read never targets the entry being written in the same cycle.
	a_no_rw_same_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_rd_en && mem_wr_en) |-> (mem_rd_addr != mem_wr_addr))
		else $error("channel memory read and write hit the same entry");

	// A transaction is never followed by another in the next cycle.
	a_one_command: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input ready in the cycle after a transaction");

	// Every entry update comes with a result in the output register.
	a_write_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		mem_wr_en |=> out_valid)
		else $error("channel entry updated without a result");
`endif

endmodule

/* tb/sv/tb_multi_channel_retransmit_timer_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Multi-channel retransmit timer testbench
// Directed tests cover start, stop, begin TB, deadline checks, time wrap and
// repeated resends. Random traffic then runs under several register settings
// with random stalls on both sides. A local timer model predicts every
// result, and each output transaction is compared field by field.
// ----------------------------------------------------------------------------
module tb_multi_channel_retransmit_timer_top;
	import rtm_pkg::*;

	localparam int unsigned NUM_CHAN = DEFAULT_NUM_CHANNELS;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned SETTLE_CYCLES = 12;
	localparam int unsigned ITEMS_PER_PHASE = 28;
	localparam int unsigned RESEND_CHECKS = 12;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [TIME_W-1:0] TIME_MAX = '1;
	localparam logic [DELAY_W-1:0] DELAY_MAX = '1;

	typedef enum int unsigned {
		PHASE_SHORT,
		PHASE_EXTREME,
		PHASE_DEFAULT,
		PHASE_WIDE
	} traffic_phase_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic cfg_write_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DELAY_W-1:0] cfg_data = '0;

	bit quiet = 1'b0;
	int unsigned stall_left = 0;
	int unsigned cycles = 0;
	int unsigned mismatches = 0;

	logic [DELAY_W-1:0] delay_reg [NUM_REGS];
	logic [NUM_CHAN-1:0] tm_active;
	logic [TIME_W-1:0] tm_deadline [NUM_CHAN];
	logic [HANDLE_W-1:0] tm_handle [NUM_CHAN];
	logic [COUNT_W-1:0] tm_count [NUM_CHAN];
	out_item_t pending_results [$];

	multi_channel_retransmit_timer_top #(
		.NUM_CHANNELS(NUM_CHAN)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_write_en(cfg_write_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 80) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [TIME_W-1:0] rand_time();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [TIME_W-1:0] chan_delay(int unsigned ch);
		if (ch < NUM_DELAY_REGS) begin
			return {{(TIME_W-DELAY_W){1'b0}}, delay_reg[ch]};
		end
		return '0;
	endfunction

	task automatic predict_timer_results(input in_item_t item);
		out_item_t res;
		logic [TIME_W-1:0] earliest;
		int unsigned ch;
		int unsigned c;
		ch = item.channel;
		res = '0;
		res.last = 1'b1;
		case (item.cmd)
			CMD_START, CMD_STOP: begin
				res.out_channel = item.channel;
				if (ch < NUM_CHAN) begin
					res.accepted = 1'b1;
					if (item.cmd == CMD_START) begin
						tm_active[ch] = 1'b1;
						tm_deadline[ch] = item.now_time + chan_delay(ch);
						tm_handle[ch] = item.msg_handle;
						tm_count[ch] = '0;
						res.out_handle = item.msg_handle;
						res.next_wake = tm_deadline[ch];
					end else begin
						tm_active[ch] = 1'b0;
						tm_handle[ch] = '0;
						res.attempt_count = tm_count[ch];
					end
				end
				pending_results.push_back(res);
			end
			CMD_BEGIN_TB: begin
				res.out_channel = CHAN_W'(TB_CH);
				if (tm_active[TB_CH]) begin
					if (tm_count[TB_CH] != '0) begin
						res.attempt_count = tm_count[TB_CH];
					end else begin
						res.accepted = 1'b1;
						res.replaced = 1'b1;
						res.out_handle = tm_handle[TB_CH];
						res.next_wake = tm_deadline[TB_CH];
						tm_handle[TB_CH] = item.msg_handle;
					end
				end else begin
					tm_active[TB_CH] = 1'b1;
					tm_deadline[TB_CH] = item.now_time +
						{{(TIME_W-DELAY_W){1'b0}}, delay_reg[REG_TB_FIRST]};
					tm_handle[TB_CH] = item.msg_handle;
					tm_count[TB_CH] = '0;
					res.accepted = 1'b1;
					res.next_wake = tm_deadline[TB_CH];
				end
				pending_results.push_back(res);
			end
			default: begin
				earliest = item.now_time +
					{{(TIME_W-DELAY_W){1'b0}}, delay_reg[REG_CHECK_INTERVAL]};
				for (c = 0; c < NUM_CHAN; c++) begin
					if (tm_active[c]) begin
						if (item.now_time > tm_deadline[c]) begin
							if (tm_count[c] != COUNT_MAX) begin
								tm_count[c] = tm_count[c] + 1'b1;
							end
							tm_deadline[c] = tm_deadline[c] + chan_delay(c);
							res = '0;
							res.out_channel = CHAN_W'(c);
							res.out_handle = tm_handle[c];
							res.attempt_count = tm_count[c];
							res.retransmit = 1'b1;
							res.accepted = 1'b1;
							pending_results.push_back(res);
						end else if (tm_deadline[c] < earliest) begin
							earliest = tm_deadline[c];
						end
					end
				end
				res = '0;
				res.accepted = 1'b1;
				res.next_wake = earliest;
				res.last = 1'b1;
				pending_results.push_back(res);
			end
		endcase
	endtask

	function automatic void check_field(string name, logic [TIME_W-1:0] want,
			logic [TIME_W-1:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0h, actual %0h", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : result_check
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("Unexpected output transaction on channel %0d",
					out_data.out_channel);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				check_field("out_channel", want.out_channel, out_data.out_channel);
				check_field("out_handle", want.out_handle, out_data.out_handle);
				check_field("attempt_count", want.attempt_count, out_data.attempt_count);
				check_field("retransmit", want.retransmit, out_data.retransmit);
				check_field("accepted", want.accepted, out_data.accepted);
				check_field("replaced", want.replaced, out_data.replaced);
				check_field("next_wake", want.next_wake, out_data.next_wake);
				check_field("last", want.last, out_data.last);
			end
		end
	end

	always @(negedge clk) begin
		if (quiet) begin
			out_ready = 1'b1;
			stall_left = 0;
		end else if (stall_left != 0) begin
			out_ready = 1'b0;
			stall_left--;
		end else begin
			out_ready = 1'b1;
			if ($urandom_range(0, 2) == 0) begin
				stall_left = idle_len();
			end
		end
	end

	task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [CHAN_W-1:0] ch,
			input logic [TIME_W-1:0] now, input logic [HANDLE_W-1:0] handle);
		in_item_t item;
		int unsigned gap;
		item.cmd = cmd;
		item.channel = ch;
		item.now_time = now;
		item.msg_handle = handle;
		gap = (quiet || $urandom_range(0, 1) == 0) ? 0 : idle_len();
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		in_data = item;
		do @(posedge clk); while (!in_ready);
		predict_timer_results(item);
		@(negedge clk);
	endtask

	task automatic wait_for_results();
		in_valid = 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DELAY_W-1:0] value);
		cfg_write_en = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_write_en = 1'b0;
		delay_reg[idx] = value;
		@(negedge clk);
	endtask

	task automatic test_start_stop();
		send_command(CMD_START, 3'd0, '0, '0);
		send_command(CMD_START, 3'd4, TIME_MAX, '1);
		send_command(CMD_START, 3'd5, rand_time(), 16'h1234);
		send_command(CMD_STOP, '1, rand_time(), 16'hFFFF);
		send_command(CMD_STOP, 3'd0, 64'd500, '0);
		send_command(CMD_STOP, 3'd4, 64'd600, '0);
	endtask

	task automatic test_begin_tb();
		wait_for_results();
		write_reg(REG_TB_FIRST, '0);
		write_reg(CFG_IDX_W'(TB_CH), DELAY_MAX);
		send_command(CMD_BEGIN_TB, '1, 64'd100, 16'hA5A5);
		send_command(CMD_BEGIN_TB, 3'd0, 64'd200, 16'h5A5A);
		send_command(CMD_CHECK, 3'd0, 64'd100, '0);
		send_command(CMD_CHECK, 3'd0, 64'd101, '0);
		send_command(CMD_BEGIN_TB, 3'd1, 64'd300, '1);
		send_command(CMD_STOP, CHAN_W'(TB_CH), 64'd400, '0);
		send_command(CMD_BEGIN_TB, 3'd3, TIME_MAX, '1);
	endtask

	task automatic test_check_scan();
		wait_for_results();
		write_reg(CFG_IDX_W'(0), '0);
		write_reg(CFG_IDX_W'(2), 32'd10);
		write_reg(CFG_IDX_W'(3), DELAY_MAX);
		write_reg(CFG_IDX_W'(4), 32'd5);
		write_reg(REG_CHECK_INTERVAL, '0);
		send_command(CMD_START, 3'd0, 64'd1000, 16'h0001);
		send_command(CMD_START, 3'd2, 64'd1000, 16'h0002);
		send_command(CMD_START, 3'd3, 64'd1000, 16'h8000);
		send_command(CMD_START, 3'd4, 64'd1000, 16'h7FFF);
		send_command(CMD_CHECK, 3'd6, 64'd1006, '0);
		send_command(CMD_CHECK, 3'd0, 64'd1000, '0);
		send_command(CMD_CHECK, 3'd0, TIME_MAX, '0);
		send_command(CMD_CHECK, 3'd0, '0, '0);
		wait_for_results();
		write_reg(REG_CHECK_INTERVAL, DELAY_MAX);
		send_command(CMD_CHECK, 3'd0, TIME_MAX, '0);
	endtask

	task automatic test_repeat_resend();
		int unsigned c;
		wait_for_results();
		quiet = 1'b1;
		write_reg(CFG_IDX_W'(0), '0);
		for (c = 1; c < NUM_CHAN; c++) begin
			send_command(CMD_STOP, CHAN_W'(c), rand_time(), '0);
		end
		send_command(CMD_START, 3'd0, 64'd1, 16'hBEEF);
		repeat (RESEND_CHECKS) begin
			send_command(CMD_CHECK, 3'd0, rand_time() | 64'h2, '0);
		end
		quiet = 1'b0;
	endtask

	function automatic logic [DELAY_W-1:0] phase_reg_value(traffic_phase_t phase);
		case (phase)
			PHASE_SHORT: return DELAY_W'($urandom_range(0, 3000));
			PHASE_EXTREME: return $urandom_range(0, 1) ? DELAY_MAX : '0;
			PHASE_DEFAULT: return DELAY_RESET;
			default: return $urandom();
		endcase
	endfunction

	function automatic int unsigned phase_step(traffic_phase_t phase);
		case (phase)
			PHASE_SHORT: return $urandom_range(0, 1500);
			PHASE_DEFAULT: return $urandom_range(0, 1500000000);
			default: return $urandom();
		endcase
	endfunction

	task automatic test_random_traffic();
		traffic_phase_t phase;
		logic [TIME_W-1:0] clock_ns;
		logic [CHAN_W-1:0] ch;
		int unsigned r;
		int unsigned i;
		int unsigned p;
		for (p = PHASE_SHORT; p <= PHASE_WIDE; p++) begin
			phase = traffic_phase_t'(p);
			wait_for_results();
			for (r = 0; r < NUM_REGS; r++) begin
				write_reg(CFG_IDX_W'(r), phase_reg_value(phase));
			end
			clock_ns = rand_time();
			for (i = 0; i < ITEMS_PER_PHASE; i++) begin
				quiet = (i >= 10 && i < 18);
				clock_ns = clock_ns + phase_step(phase);
				ch = CHAN_W'($urandom_range(0, NUM_CHAN - 1));
				if ($urandom_range(0, 9) == 0) begin
					ch = CHAN_W'($urandom_range(NUM_CHAN, (1 << CHAN_W) - 1));
				end
				r = $urandom_range(0, 99);
				if (r < 35) begin
					send_command(CMD_CHECK, CHAN_W'($urandom()), clock_ns, HANDLE_W'($urandom()));
				end else if (r < 65) begin
					send_command(CMD_START, ch, clock_ns, HANDLE_W'($urandom()));
				end else if (r < 80) begin
					send_command(CMD_BEGIN_TB, CHAN_W'($urandom()), clock_ns,
						HANDLE_W'($urandom()));
				end else if (r < 90) begin
					send_command(CMD_STOP, ch, clock_ns, HANDLE_W'($urandom()));
				end else begin
					send_command(CMD_W'($urandom()), CHAN_W'($urandom()), rand_time(),
						HANDLE_W'($urandom()));
				end
				if (i == ITEMS_PER_PHASE / 2 || $urandom_range(0, 29) == 0) begin
					wait_for_results();
				end
			end
			quiet = 1'b0;
		end
	endtask

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int unsigned i;
		for (i = 0; i < NUM_REGS; i++) begin
			delay_reg[i] = DELAY_RESET;
		end
		tm_active = '0;
		for (i = 0; i < NUM_CHAN; i++) begin
			tm_deadline[i] = '0;
			tm_handle[i] = '0;
			tm_count[i] = '0;
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		test_start_stop();
		test_begin_tb();
		test_check_scan();
		test_repeat_resend();
		test_random_traffic();

		wait_for_results();
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

/* multi_channel_retransmit_timer_top.f */
sv/rtm_pkg.sv
sv/rtm_cfg_regs.sv
sv/rtm_chan_mem.sv
sv/rtm_seq.sv
sv/multi_channel_retransmit_timer_top.sv
tb/sv/tb_multi_channel_retransmit_timer_top.sv
